// ===== rtl/bls_pkg.sv =====
// Shared types, constants and helpers for the battery level supervisor.
package bls_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = 16;
  localparam int BAND_CNT_W  = 4;
  localparam int HALT_CNT_W  = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int BATCH_SIZE_DEF       = 16;
  localparam int GOOD_COUNT_LIMIT_DEF = 8;
  localparam int LOW_COUNT_LIMIT_DEF  = 8;
  localparam int DEAD_COUNT_LIMIT_DEF = 8;
  localparam int HALT_TICKS_DEF       = 30;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // reciprocal shift for an exact mean of the 16-bit sample sum with a batch of up to 32
  localparam int MEAN_SHIFT = 21;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN_INIT = 12'hFFF;

  typedef enum logic [1:0] {
    LVL_DEAD = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_GOOD = 2'd2,
    LVL_NONE = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    MODE_RUN = 2'd0,
    MODE_LOW = 2'd1,
    MODE_DIS = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    LED_OFF    = 3'd0,
    LED_ORANGE = 3'd1,
    LED_GREEN  = 3'd2,
    LED_RED    = 3'd3,
    LED_SAME   = 3'd4
  } led_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD_LOW  = 2'd0,
    CFG_THRESHOLD_DEAD = 2'd1,
    CFG_CHECKING_EN    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SAMPLE_W-1:0] sample;
    logic                blink_off;
  } cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean_level;
    logic [SAMPLE_W-1:0] spread;
    level_t              battery_level;
    mode_t               system_mode;
    led_t                led_color;
    logic                brake_motors;
    logic                shutdown;
  } result_t;

  function automatic logic [BAND_CNT_W-1:0] band_bump(input logic [BAND_CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

// ===== rtl/battery_level_supervisor.sv =====
// Top level of the battery level supervisor: ports, queues and checks.
//
// Accepts one transaction per clock while not full, an ADC sample or a
// periodic tick, and returns one result per tick. A command queue separates
// the input classifier from the back end, which retires one command per cycle
// while the result queue has room; a result queue holds finished results and
// absorbs short consumer stalls, while a longer stall fills both queues and
// raises full. The back end update (batch mean by reciprocal multiply, band
// compare, counter update) is combinational and sets the sustained rate of
// one transaction per cycle when nothing stalls. No clearing pass after
// reset; configuration writes take effect at the next edge.
module battery_level_supervisor #(
  parameter int BATCH_SIZE       = bls_pkg::BATCH_SIZE_DEF,
  parameter int GOOD_COUNT_LIMIT = bls_pkg::GOOD_COUNT_LIMIT_DEF,
  parameter int LOW_COUNT_LIMIT  = bls_pkg::LOW_COUNT_LIMIT_DEF,
  parameter int DEAD_COUNT_LIMIT = bls_pkg::DEAD_COUNT_LIMIT_DEF,
  parameter int HALT_TICKS       = bls_pkg::HALT_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            action,
  input  logic [bls_pkg::SAMPLE_W-1:0]    sample,
  input  logic [7:0]                      blink_phase,
  output logic                            empty,
  input  logic                            pop,
  output logic [bls_pkg::SAMPLE_W-1:0]    mean_level,
  output logic [bls_pkg::SAMPLE_W-1:0]    spread,
  output logic [1:0]                      battery_level,
  output logic [1:0]                      system_mode,
  output logic [2:0]                      led_color,
  output logic                            brake_motors,
  output logic                            shutdown,
  input  logic                            write_enable,
  input  logic [bls_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [bls_pkg::CFG_DATA_W-1:0]  write_data
);

  bls_pkg::cmd_t       cmd_in;
  bls_pkg::cmd_t       cmd_out;
  logic                cmd_push;
  logic                cmd_full;
  logic                cmd_empty;
  logic                cmd_pop;
  bls_pkg::result_t    res_in;
  bls_pkg::result_t    res_out;
  logic                res_push;
  logic                res_full;
  bls_pkg::cfg_write_t cfg;

  assign cfg.en    = write_enable;
  assign cfg.index = write_index;
  assign cfg.data  = write_data;
  assign full      = cmd_full;

  bls_front u_front (
    .push        (push),
    .action      (action),
    .sample      (sample),
    .blink_phase (blink_phase),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  bls_queue #(
    .WIDTH ($bits(bls_pkg::cmd_t)),
    .DEPTH (bls_pkg::CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  bls_back #(
    .BATCH_SIZE       (BATCH_SIZE),
    .GOOD_COUNT_LIMIT (GOOD_COUNT_LIMIT),
    .LOW_COUNT_LIMIT  (LOW_COUNT_LIMIT),
    .DEAD_COUNT_LIMIT (DEAD_COUNT_LIMIT),
    .HALT_TICKS       (HALT_TICKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  bls_queue #(
    .WIDTH ($bits(bls_pkg::result_t)),
    .DEPTH (bls_pkg::RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign mean_level    = res_out.mean_level;
  assign spread        = res_out.spread;
  assign battery_level = res_out.battery_level;
  assign system_mode   = res_out.system_mode;
  assign led_color     = res_out.led_color;
  assign brake_motors  = res_out.brake_motors;
  assign shutdown      = res_out.shutdown;

  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_brake_means_dead: assert property (@(posedge clk) disable iff (rst)
    (!empty && brake_motors) |->
      (battery_level == bls_pkg::LVL_DEAD && system_mode == bls_pkg::MODE_DIS))
    else $error("brake without dead level and disabled mode");

  a_shutdown_means_disabled: assert property (@(posedge clk) disable iff (rst)
    (!empty && shutdown) |-> (system_mode == bls_pkg::MODE_DIS))
    else $error("shutdown outside disabled mode");

  a_pop_only_when_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("back end retired a command from an empty queue");

endmodule

// ===== rtl/bls_queue.sv =====
// Small first-in first-out queue between the front, back and result ports.
module bls_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/bls_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
module bls_front (
  input  logic                          push,
  input  logic                          action,
  input  logic [bls_pkg::SAMPLE_W-1:0]  sample,
  input  logic [7:0]                    blink_phase,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output bls_pkg::cmd_t                 cmd
);

  assign cmd_push = push && !cmd_full;

  always_comb begin
    cmd.kind      = action ? bls_pkg::CMD_TICK : bls_pkg::CMD_SAMPLE;
    cmd.sample    = action ? '0 : sample;
    cmd.blink_off = blink_phase[0];
  end

endmodule

// ===== rtl/bls_back.sv =====
// Back end: batch statistics, band counters, mode tracking and result building.
module bls_back #(
  parameter int BATCH_SIZE       = bls_pkg::BATCH_SIZE_DEF,
  parameter int GOOD_COUNT_LIMIT = bls_pkg::GOOD_COUNT_LIMIT_DEF,
  parameter int LOW_COUNT_LIMIT  = bls_pkg::LOW_COUNT_LIMIT_DEF,
  parameter int DEAD_COUNT_LIMIT = bls_pkg::DEAD_COUNT_LIMIT_DEF,
  parameter int HALT_TICKS       = bls_pkg::HALT_TICKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bls_pkg::cfg_write_t cfg,
  input  logic                cmd_valid,
  input  bls_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output bls_pkg::result_t    res
);

  localparam int SW = bls_pkg::SAMPLE_W;
  localparam int CW = $clog2(BATCH_SIZE + 1);
  localparam int BW = bls_pkg::BAND_CNT_W;
  localparam int HW = bls_pkg::HALT_CNT_W;
  localparam int PW = bls_pkg::SUM_W + bls_pkg::MEAN_SHIFT;
  localparam logic [bls_pkg::MEAN_SHIFT-1:0] MEAN_MULT = bls_pkg::MEAN_SHIFT'(
    ((1 << bls_pkg::MEAN_SHIFT) + BATCH_SIZE - 1) / BATCH_SIZE);

  logic [SW-1:0]            threshold_low;
  logic [SW-1:0]            threshold_dead;
  logic                     checking_enable;

  logic [bls_pkg::SUM_W-1:0] sample_sum, sample_sum_next;
  logic [SW-1:0]            sample_min, sample_min_next;
  logic [SW-1:0]            sample_max, sample_max_next;
  logic [CW-1:0]            sample_count, sample_count_next;
  logic [BW-1:0]            good_count, good_count_next;
  logic [BW-1:0]            low_count, low_count_next;
  logic [BW-1:0]            dead_count, dead_count_next;
  logic [HW-1:0]            halt_count, halt_count_next;
  bls_pkg::level_t          level_now, level_now_next;
  bls_pkg::mode_t           mode_now, mode_now_next;
  logic                     halted, halted_next;
  logic [SW-1:0]            mean_last, mean_last_next;
  logic [SW-1:0]            spread_last, spread_last_next;

  logic [PW-1:0]            mean_prod;
  logic [SW-1:0]            mean;
  logic                     batch_full;
  bls_pkg::led_t            led;
  logic                     brake;
  logic                     shut;

  assign mean_prod  = PW'(sample_sum) * PW'(MEAN_MULT);
  assign mean       = mean_prod[bls_pkg::MEAN_SHIFT +: SW];
  assign batch_full = (sample_count >= CW'(BATCH_SIZE));
  assign cmd_pop    = cmd_valid && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_low   <= '0;
      threshold_dead  <= '0;
      checking_enable <= 1'b1;
    end else if (cfg.en) begin
      case (cfg.index)
        bls_pkg::CFG_THRESHOLD_LOW:  threshold_low   <= cfg.data;
        bls_pkg::CFG_THRESHOLD_DEAD: threshold_dead  <= cfg.data;
        bls_pkg::CFG_CHECKING_EN:    checking_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sample_sum_next   = sample_sum;
    sample_min_next   = sample_min;
    sample_max_next   = sample_max;
    sample_count_next = sample_count;
    good_count_next   = good_count;
    low_count_next    = low_count;
    dead_count_next   = dead_count;
    halt_count_next   = halt_count;
    level_now_next    = level_now;
    mode_now_next     = mode_now;
    halted_next       = halted;
    mean_last_next    = mean_last;
    spread_last_next  = spread_last;
    led               = bls_pkg::LED_SAME;
    brake             = 1'b0;
    shut              = 1'b0;
    res_push          = 1'b0;

    if (cmd_pop) begin
      case (cmd.kind)
        bls_pkg::CMD_SAMPLE: begin
          if (!halted && !batch_full) begin
            sample_sum_next   = sample_sum + bls_pkg::SUM_W'(cmd.sample);
            sample_min_next   = (cmd.sample < sample_min) ? cmd.sample : sample_min;
            sample_max_next   = (cmd.sample > sample_max) ? cmd.sample : sample_max;
            sample_count_next = sample_count + 1'b1;
          end
        end
        bls_pkg::CMD_TICK: begin
          res_push = 1'b1;
          if (halted) begin
            shut = 1'b1;
          end else begin
            if (batch_full && checking_enable) begin
              mean_last_next    = mean;
              spread_last_next  = (sample_max >= sample_min) ? sample_max - sample_min : '0;
              sample_sum_next   = '0;
              sample_min_next   = bls_pkg::SAMPLE_MIN_INIT;
              sample_max_next   = '0;
              sample_count_next = '0;
              if (mean >= threshold_low) begin
                good_count_next = bls_pkg::band_bump(good_count);
                if (good_count_next >= BW'(GOOD_COUNT_LIMIT)) begin
                  if (mode_now == bls_pkg::MODE_LOW) mode_now_next = bls_pkg::MODE_RUN;
                  level_now_next  = bls_pkg::LVL_GOOD;
                  good_count_next = '0;
                  low_count_next  = '0;
                  dead_count_next = '0;
                  halt_count_next = '0;
                end
              end else if (mean >= threshold_dead) begin
                low_count_next = bls_pkg::band_bump(low_count);
                if (low_count_next >= BW'(LOW_COUNT_LIMIT)) begin
                  if (mode_now == bls_pkg::MODE_RUN) mode_now_next = bls_pkg::MODE_LOW;
                  level_now_next  = bls_pkg::LVL_LOW;
                  good_count_next = '0;
                  low_count_next  = '0;
                  dead_count_next = '0;
                end
              end else begin
                dead_count_next = bls_pkg::band_bump(dead_count);
                if (dead_count_next >= BW'(DEAD_COUNT_LIMIT)) begin
                  mode_now_next   = bls_pkg::MODE_DIS;
                  level_now_next  = bls_pkg::LVL_DEAD;
                  good_count_next = '0;
                  low_count_next  = '0;
                  dead_count_next = '0;
                  brake           = 1'b1;
                end
              end
            end
            if (mode_now_next == bls_pkg::MODE_DIS) begin
              led = cmd.blink_off ? bls_pkg::LED_OFF : bls_pkg::LED_RED;
              if (halt_count_next != '1) halt_count_next = halt_count_next + 1'b1;
              if (halt_count_next >= HW'(HALT_TICKS)) begin
                shut        = 1'b1;
                halted_next = 1'b1;
              end
            end else begin
              case (level_now_next)
                bls_pkg::LVL_LOW:  led = bls_pkg::LED_ORANGE;
                bls_pkg::LVL_GOOD: led = bls_pkg::LED_GREEN;
                default:           led = bls_pkg::LED_SAME;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.mean_level    = mean_last_next;
    res.spread        = spread_last_next;
    res.battery_level = level_now_next;
    res.system_mode   = mode_now_next;
    res.led_color     = led;
    res.brake_motors  = brake;
    res.shutdown      = shut;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_min   <= bls_pkg::SAMPLE_MIN_INIT;
      sample_max   <= '0;
      sample_count <= '0;
      good_count   <= '0;
      low_count    <= '0;
      dead_count   <= '0;
      halt_count   <= '0;
      level_now    <= bls_pkg::LVL_NONE;
      mode_now     <= bls_pkg::MODE_RUN;
      halted       <= 1'b0;
      mean_last    <= '0;
      spread_last  <= '0;
    end else begin
      sample_sum   <= sample_sum_next;
      sample_min   <= sample_min_next;
      sample_max   <= sample_max_next;
      sample_count <= sample_count_next;
      good_count   <= good_count_next;
      low_count    <= low_count_next;
      dead_count   <= dead_count_next;
      halt_count   <= halt_count_next;
      level_now    <= level_now_next;
      mode_now     <= mode_now_next;
      halted       <= halted_next;
      mean_last    <= mean_last_next;
      spread_last  <= spread_last_next;
    end
  end

endmodule

// ===== verif/bls_checker.sv =====
// Checker for the battery level supervisor: predicts each tick result and compares it.
`timescale 1ns / 100ps
module bls_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic                            action,
  input  logic [bls_pkg::SAMPLE_W-1:0]    sample,
  input  logic [7:0]                      blink_phase,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [bls_pkg::SAMPLE_W-1:0]    mean_level,
  input  logic [bls_pkg::SAMPLE_W-1:0]    spread,
  input  logic [1:0]                      battery_level,
  input  logic [1:0]                      system_mode,
  input  logic [2:0]                      led_color,
  input  logic                            brake_motors,
  input  logic                            shutdown,
  input  logic                            write_enable,
  input  logic [bls_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [bls_pkg::CFG_DATA_W-1:0]  write_data,
  output int                              mismatch_count,
  output int                              reports_pending,
  output int                              reports_checked,
  output int                              brakes_seen,
  output int                              shutdowns_seen
);
  import bls_pkg::*;

  logic [SAMPLE_W-1:0]   thr_low, thr_dead;
  logic                  chk_en;
  logic [SUM_W-1:0]      acc_sum;
  logic [SAMPLE_W-1:0]   acc_min, acc_max;
  logic [4:0]            acc_n;
  logic [BAND_CNT_W-1:0] good_n, low_n, dead_n;
  logic [HALT_CNT_W-1:0] halt_n;
  level_t                level_now;
  mode_t                 mode_now;
  logic                  halted;
  logic [SAMPLE_W-1:0]   last_mean, last_spread;
  result_t               expected_reports[$];

  task automatic restart_batch();
    acc_sum = '0;
    acc_min = SAMPLE_MIN_INIT;
    acc_max = '0;
    acc_n   = '0;
  endtask

  task automatic battery_step(input logic act, input logic [SAMPLE_W-1:0] smp,
                              input logic [7:0] ph);
    result_t             r;
    logic [SAMPLE_W-1:0] mean;
    led_t                led;
    logic                brake, shut;
    led   = LED_SAME;
    brake = 1'b0;
    shut  = 1'b0;
    if (cmd_kind_t'(act) == CMD_SAMPLE) begin
      if (!halted && acc_n < BATCH_SIZE_DEF) begin
        acc_sum = acc_sum + SUM_W'(smp);
        if (smp < acc_min) acc_min = smp;
        if (smp > acc_max) acc_max = smp;
        acc_n = acc_n + 1'b1;
      end
    end else begin
      if (halted) begin
        shut = 1'b1;
      end else begin
        if (acc_n >= BATCH_SIZE_DEF && chk_en) begin
          mean        = SAMPLE_W'(acc_sum / BATCH_SIZE_DEF);
          last_mean   = mean;
          last_spread = (acc_max >= acc_min) ? acc_max - acc_min : '0;
          restart_batch();
          if (mean >= thr_low) begin
            good_n = (good_n == '1) ? good_n : good_n + 1'b1;
            if (good_n >= GOOD_COUNT_LIMIT_DEF) begin
              if (mode_now == MODE_LOW) mode_now = MODE_RUN;
              level_now = LVL_GOOD;
              good_n = '0;
              low_n  = '0;
              dead_n = '0;
              halt_n = '0;
            end
          end else if (mean >= thr_dead) begin
            low_n = (low_n == '1) ? low_n : low_n + 1'b1;
            if (low_n >= LOW_COUNT_LIMIT_DEF) begin
              if (mode_now == MODE_RUN) mode_now = MODE_LOW;
              level_now = LVL_LOW;
              good_n = '0;
              low_n  = '0;
              dead_n = '0;
            end
          end else begin
            dead_n = (dead_n == '1) ? dead_n : dead_n + 1'b1;
            if (dead_n >= DEAD_COUNT_LIMIT_DEF) begin
              mode_now  = MODE_DIS;
              level_now = LVL_DEAD;
              good_n = '0;
              low_n  = '0;
              dead_n = '0;
              brake  = 1'b1;
            end
          end
        end
        if (mode_now == MODE_DIS) begin
          led = ph[0] ? LED_OFF : LED_RED;
          if (halt_n != '1) halt_n = halt_n + 1'b1;
          if (halt_n >= HALT_TICKS_DEF) begin
            shut   = 1'b1;
            halted = 1'b1;
          end
        end else if (level_now == LVL_LOW) begin
          led = LED_ORANGE;
        end else if (level_now == LVL_GOOD) begin
          led = LED_GREEN;
        end
      end
      r.mean_level    = last_mean;
      r.spread        = last_spread;
      r.battery_level = level_now;
      r.system_mode   = mode_now;
      r.led_color     = led;
      r.brake_motors  = brake;
      r.shutdown      = shut;
      expected_reports.push_back(r);
    end
  endtask

  task automatic compare_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      thr_low   = '0;
      thr_dead  = '0;
      chk_en    = 1'b1;
      restart_batch();
      good_n    = '0;
      low_n     = '0;
      dead_n    = '0;
      halt_n    = '0;
      level_now = LVL_NONE;
      mode_now  = MODE_RUN;
      halted    = 1'b0;
      last_mean   = '0;
      last_spread = '0;
      expected_reports.delete();
      mismatch_count  = 0;
      reports_pending = 0;
      reports_checked = 0;
      brakes_seen     = 0;
      shutdowns_seen  = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mean %0d spread %0d",
                   $time, mean_level, spread);
          $display("%0t:   level %0d mode %0d led %0d brake %0d shutdown %0d",
                   $time, battery_level, system_mode, led_color, brake_motors, shutdown);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("mean_level", want.mean_level, mean_level);
          compare_field("spread", want.spread, spread);
          compare_field("battery_level", want.battery_level, battery_level);
          compare_field("system_mode", want.system_mode, system_mode);
          compare_field("led_color", want.led_color, led_color);
          compare_field("brake_motors", want.brake_motors, brake_motors);
          compare_field("shutdown", want.shutdown, shutdown);
          reports_checked++;
          if (brake_motors) brakes_seen++;
          if (shutdown) shutdowns_seen++;
        end
      end
      if (push && !full) battery_step(action, sample, blink_phase);
      if (write_enable) begin
        case (cfg_index_t'(write_index))
          CFG_THRESHOLD_LOW:  thr_low  = write_data;
          CFG_THRESHOLD_DEAD: thr_dead = write_data;
          CFG_CHECKING_EN:    chk_en   = write_data[0];
          default: ;
        endcase
      end
      reports_pending = expected_reports.size();
    end
  end

endmodule

// ===== verif/tb_battery_level_supervisor.sv =====
// Testbench top for the battery level supervisor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_battery_level_supervisor;
  import bls_pkg::*;

  localparam int     CLK_PERIOD    = 10;
  localparam int     PHASES        = 10;
  localparam int     EARLY_BUDGET  = 95;
  localparam int     LATE_BUDGET   = 200;
  localparam int     TAIL_TICKS    = 48;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam longint TIMEOUT_NS    = 2000000;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic                   action = 1'b0;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic [7:0]             blink_phase = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [SAMPLE_W-1:0]    mean_level, spread;
  logic [1:0]             battery_level, system_mode;
  logic [2:0]             led_color;
  logic                   brake_motors, shutdown;
  logic                   write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] write_index = '0;
  logic [CFG_DATA_W-1:0]  write_data = '0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic steady_feed = 1'b0;
  logic steady_drain = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   cur_low = 0;
  int   cur_dead = 0;
  int   items_sent = 0;
  int   ticks_sent = 0;
  int   settings_written = 0;
  int   mismatch_count, reports_pending, reports_checked, brakes_seen, shutdowns_seen;

  battery_level_supervisor dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action), .sample(sample),
    .blink_phase(blink_phase), .empty(empty), .pop(pop), .mean_level(mean_level),
    .spread(spread), .battery_level(battery_level), .system_mode(system_mode),
    .led_color(led_color), .brake_motors(brake_motors), .shutdown(shutdown),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  bls_checker level_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action), .sample(sample),
    .blink_phase(blink_phase), .empty(empty), .pop(pop), .mean_level(mean_level),
    .spread(spread), .battery_level(battery_level), .system_mode(system_mode),
    .led_color(led_color), .brake_motors(brake_motors), .shutdown(shutdown),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .mismatch_count(mismatch_count), .reports_pending(reports_pending),
    .reports_checked(reports_checked), .brakes_seen(brakes_seen),
    .shutdowns_seen(shutdowns_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    in_fire  <= push && !full;
    out_fire <= pop && !empty;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  task automatic offer(input logic act, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    action      <= act;
    sample      <= smp;
    blink_phase <= 8'($urandom_range(0, 255));
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    items_sent++;
    if (act == CMD_TICK) ticks_sent++;
  endtask

  task automatic drain();
    int k;
    push <= 1'b0;
    k = 0;
    while (reports_pending != 0 && k < DRAIN_LIMIT) begin
      @(negedge clk);
      k++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] dd,
                           input logic en);
    write_enable <= 1'b1;
    write_index  <= CFG_THRESHOLD_LOW;
    write_data   <= lo;
    @(negedge clk);
    write_index <= CFG_THRESHOLD_DEAD;
    write_data  <= dd;
    @(negedge clk);
    write_index <= CFG_CHECKING_EN;
    write_data  <= {11'($urandom), en};
    @(negedge clk);
    write_index <= CFG_SPARE;
    write_data  <= CFG_DATA_W'($urandom);
    @(negedge clk);
    write_enable <= 1'b0;
    cur_low  = lo;
    cur_dead = dd;
    settings_written++;
  endtask

  task automatic noise_burst(input int n);
    repeat (n) offer(1'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, 4095)));
  endtask

  // pairs of samples around a target mean inside the requested band, then a tick
  task automatic batch_round(input level_t band, input int n);
    int lo, hi, target, dev, floor_v;
    floor_v = (cur_low < cur_dead) ? cur_low : cur_dead;
    if (band == LVL_DEAD && floor_v > 0) begin
      lo = 0;
      hi = floor_v - 1;
    end else if (band == LVL_LOW && cur_dead < cur_low) begin
      lo = cur_dead;
      hi = cur_low - 1;
    end else begin
      lo = cur_low;
      hi = 4095;
    end
    target = $urandom_range(hi, lo);
    dev = $urandom_range(0, 300);
    if (dev > target) dev = target;
    if (dev > 4095 - target) dev = 4095 - target;
    for (int i = 0; i < n; i++)
      offer(CMD_SAMPLE, SAMPLE_W'(i[0] ? target - dev : target + dev));
    offer(CMD_TICK, SAMPLE_W'($urandom_range(0, 4095)));
  endtask

  initial begin : result_taker
    int wait_n;
    int taken;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        wait_n = steady_drain ? 0 : $urandom_range(0, 15);
        if (wait_n > 0) begin
          pop <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
      end
      pop <= 1'b1;
      @(negedge clk);
      while (!out_fire) @(negedge clk);
      taken++;
      if (taken % 20 == 0) steady_drain = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    int     lo, dd, budget_end, kind;
    logic   en, late;
    level_t favored, band;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // tick on an empty batch, full batch of extremes, ignored extra sample, evaluation
    offer(CMD_TICK, 12'hFFF);
    for (int i = 0; i < BATCH_SIZE_DEF; i++) offer(CMD_SAMPLE, i[0] ? 12'hFFF : 12'h000);
    offer(CMD_SAMPLE, 12'hFFF);
    offer(CMD_TICK, 12'h000);
    offer(CMD_TICK, 12'hFFF);

    for (int p = 0; p < PHASES; p++) begin
      late = (p >= PHASES - 2);
      case (p)
        0: begin
          lo = 4095;
          dd = 0;
          en = 1'b1;
        end
        1: begin
          lo = 0;
          dd = 0;
          en = 1'b0;
        end
        PHASES - 2: begin
          lo = $urandom_range(256, 4095);
          dd = 4095;
          en = 1'b1;
        end
        PHASES - 1: begin
          lo = $urandom_range(256, 4095);
          dd = $urandom_range(256, 4095);
          en = 1'b1;
        end
        default: begin
          lo = $urandom_range(0, 4095);
          dd = $urandom_range(0, 255);
          en = ($urandom_range(0, 4) != 0);
        end
      endcase
      drain();
      write_cfg(CFG_DATA_W'(lo), CFG_DATA_W'(dd), en);
      steady_feed = (p == 3) || ($urandom_range(0, 3) == 0);
      if (p == 3) hold_req = 1'b1;
      favored = late ? LVL_DEAD : ($urandom_range(0, 1) ? LVL_GOOD : LVL_LOW);
      budget_end = items_sent + (late ? LATE_BUDGET : EARLY_BUDGET);
      while (items_sent < budget_end) begin
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 7) != 0) band = favored;
        else if (late && $urandom_range(0, 2) == 0) band = LVL_DEAD;
        else band = $urandom_range(0, 1) ? LVL_GOOD : LVL_LOW;
        if (kind == 0) noise_burst($urandom_range(1, 6));
        else if (kind == 1) batch_round(band, $urandom_range(1, BATCH_SIZE_DEF - 1));
        else if (kind == 2) batch_round(band, $urandom_range(BATCH_SIZE_DEF + 1, 20));
        else batch_round(band, BATCH_SIZE_DEF);
      end
    end

    // run out the halt count if the supervisor went disabled
    steady_feed = 1'b0;
    for (int i = 0; i < TAIL_TICKS; i++) begin
      offer(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 4095)));
      offer(CMD_TICK, SAMPLE_W'($urandom_range(0, 4095)));
    end
    drain();
    write_cfg(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'($urandom));
    noise_burst(10);
    drain();

    $display("covered %0d input transactions (%0d ticks) across %0d register settings",
             items_sent, ticks_sent, settings_written);
    $display("checked %0d results, %0d with motor brake, %0d with shutdown",
             reports_checked, brakes_seen, shutdowns_seen);
    if (reports_pending != 0) $display("%0d expected results never arrived", reports_pending);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== battery_level_supervisor.f =====
rtl/bls_pkg.sv
rtl/bls_queue.sv
rtl/bls_front.sv
rtl/bls_back.sv
rtl/battery_level_supervisor.sv
verif/bls_checker.sv
verif/tb_battery_level_supervisor.sv
